// ----- design/bbfa_pkg.sv -----
package bbfa_pkg;

  // Field widths of the channels and the configuration register.
  localparam int unsigned SizeW  = 11;
  localparam int unsigned StartW = 10;
  localparam int unsigned UnitsW = 11;

  // Reset value of the in-use memory size.
  localparam logic [UnitsW-1:0] UnitsReset = 11'd1024;

  // Request action codes.
  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  // Response status codes.
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusNoFit = 1'b1;

endpackage

// ----- design/bbfa_req_if.sv -----
interface bbfa_req_if;

  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [bbfa_pkg::SizeW-1:0]       block_size;
  logic [bbfa_pkg::StartW-1:0]      free_start;

  modport source (output valid, action, block_size, free_start, input ready);
  modport sink (input valid, action, block_size, free_start, output ready);

endinterface

// ----- design/bbfa_rsp_if.sv -----
interface bbfa_rsp_if;

  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [bbfa_pkg::StartW-1:0] block_start;

  modport source (output valid, status, block_start, input ready);
  modport sink (input valid, status, block_start, output ready);

endinterface

// ----- design/bbfa_cfg_if.sv -----
interface bbfa_cfg_if;

  logic                        valid;
  logic                        ready;
  logic [bbfa_pkg::UnitsW-1:0] mem_units;

  modport source (output valid, mem_units, input ready);
  modport sink (input valid, mem_units, output ready);

endinterface

// ----- design/bbfa_map_ram.sv -----
module bbfa_map_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic             wdata_i,
  output logic             rdata_o
);

  logic mem_q [Depth];
  logic rdata_q;

  // Single-port occupancy map, one bit per unit, registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bitmap_best_fit_allocator_core.sv -----
// Best-fit contiguous allocator over a one-bit-per-unit occupancy map.
// Channels: req_i carries one transaction per request (action, block_size,
// free_start); rsp_o returns exactly one transaction per request (status,
// block_start), in request order; cfg_i writes the in-use size mem_units.
// An allocation scans the map one unit per cycle through the single map RAM
// port, then marks the chosen run one unit per cycle. A free writes one unit
// per cycle and stops after block_size units or at the in-use size,
// whichever comes first.
// One request is worked on at a time. The response sits in an output
// register, so the next request is accepted while a response still waits;
// when the receiver stalls, a finished second request holds until the
// output register is taken.
// After reset the map RAM is cleared to all free, one unit per cycle, over
// all MEM_UNITS_MAX units; req_i is not ready during that pass. Configuration
// writes are taken at any time and should only come while the block is idle.
module bitmap_best_fit_allocator_core #(
  parameter int unsigned MEM_UNITS_MAX = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbfa_req_if.sink  req_i,
  bbfa_rsp_if.source rsp_o,
  bbfa_cfg_if.sink  cfg_i
);

  localparam int unsigned AW  = (MEM_UNITS_MAX > 1) ? $clog2(MEM_UNITS_MAX) : 1;
  localparam int unsigned UW  = $clog2(MEM_UNITS_MAX + 1);
  localparam int unsigned LW  = ((UW > bbfa_pkg::UnitsW) ? UW : bbfa_pkg::UnitsW) + 1;

  localparam logic [LW-1:0] MaxUnits = LW'(MEM_UNITS_MAX);
  localparam logic [LW-1:0] LastAddr = LW'(MEM_UNITS_MAX - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [bbfa_pkg::UnitsW-1:0] mem_units_q, mem_units_d;
  logic [bbfa_pkg::SizeW-1:0]  size_q, size_d;
  logic [LW-1:0] rd_q, rd_d;
  logic          pend_q, pend_d;
  logic [LW-1:0] pidx_q, pidx_d;
  logic [LW-1:0] run_len_q, run_len_d;
  logic [LW-1:0] run_start_q, run_start_d;
  logic          found_q, found_d;
  logic [LW-1:0] best_start_q, best_start_d;
  logic [LW-1:0] best_margin_q, best_margin_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          wbit_q, wbit_d;
  logic          res_status_q, res_status_d;
  logic [bbfa_pkg::StartW-1:0] res_start_q, res_start_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic          rsp_status_q, rsp_status_d;
  logic [bbfa_pkg::StartW-1:0] rsp_start_q, rsp_start_d;

  logic [LW-1:0] units;
  logic [LW-1:0] cfg_ext;
  logic [LW-1:0] size_ext;
  logic [LW-1:0] margin;
  logic          used;
  logic          fit_better;
  logic          write_go;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic          ram_wdata;
  logic          ram_rdata;
  logic          req_fire;

  // In-use size, clipped at the map depth.
  assign cfg_ext  = LW'(mem_units_q);
  assign units    = (cfg_ext > MaxUnits) ? MaxUnits : cfg_ext;
  assign size_ext = LW'(size_q);

  // Scan step: the position past the in-use size counts as used and closes
  // the last run.
  assign used       = (pidx_q == units) || ram_rdata;
  assign margin     = run_len_q - size_ext;
  assign fit_better = pend_q && used && (run_len_q != '0) && (run_len_q >= size_ext) &&
                      (!found_q || (margin < best_margin_q));

  // Write phase runs while units remain and stays below the in-use size.
  assign write_go = (cnt_q < size_ext) && (pos_q < units);

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.block_start = rsp_start_q;

  // Map RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = pos_q[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        ram_addr = rd_q[AW-1:0];
      end
      S_WRITE: begin
        ram_we    = write_go;
        ram_wdata = wbit_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bbfa_map_ram #(
    .Depth (MEM_UNITS_MAX),
    .AddrW (AW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_d       = state_q;
    mem_units_d   = mem_units_q;
    size_d        = size_q;
    rd_d          = rd_q;
    pend_d        = 1'b0;
    pidx_d        = pidx_q;
    run_len_d     = run_len_q;
    run_start_d   = run_start_q;
    found_d       = found_q;
    best_start_d  = best_start_q;
    best_margin_d = best_margin_q;
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    wbit_d        = wbit_q;
    res_status_d  = res_status_q;
    res_start_d   = res_start_q;
    rsp_valid_d   = rsp_valid_q;
    rsp_status_d  = rsp_status_q;
    rsp_start_d   = rsp_start_q;

    if (cfg_i.valid) begin
      mem_units_d = cfg_i.mem_units;
    end

    // The receiver takes the response.
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        pos_d = pos_q + LW'(1);
        if (pos_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_fire) begin
          size_d = req_i.block_size;
          if (req_i.action == bbfa_pkg::ActFree) begin
            pos_d        = LW'(req_i.free_start);
            cnt_d        = '0;
            wbit_d       = 1'b0;
            res_status_d = bbfa_pkg::StatusOk;
            res_start_d  = '0;
            state_d      = S_WRITE;
          end else begin
            rd_d      = '0;
            run_len_d = '0;
            found_d   = 1'b0;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle up to and including the end position.
        if (rd_q <= units) begin
          pend_d = 1'b1;
          pidx_d = rd_q;
          rd_d   = rd_q + LW'(1);
        end
        // Consume the read issued in the previous cycle.
        if (pend_q) begin
          if (!used) begin
            if (run_len_q == '0) begin
              run_start_d = pidx_q;
            end
            run_len_d = run_len_q + LW'(1);
          end else begin
            run_len_d = '0;
          end
          if (fit_better) begin
            found_d       = 1'b1;
            best_margin_d = margin;
            best_start_d  = run_start_q;
          end
          if (pidx_q == units) begin
            pend_d = 1'b0;
            if (found_q || fit_better) begin
              pos_d        = fit_better ? run_start_q : best_start_q;
              cnt_d        = '0;
              wbit_d       = 1'b1;
              res_status_d = bbfa_pkg::StatusOk;
              res_start_d  = fit_better ? run_start_q[bbfa_pkg::StartW-1:0]
                                        : best_start_q[bbfa_pkg::StartW-1:0];
              state_d      = S_WRITE;
            end else begin
              res_status_d = bbfa_pkg::StatusNoFit;
              res_start_d  = '0;
              state_d      = S_DONE;
            end
          end
        end
      end

      S_WRITE: begin
        if (write_go) begin
          pos_d = pos_q + LW'(1);
          cnt_d = cnt_q + LW'(1);
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_start_d  = res_start_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      mem_units_q   <= bbfa_pkg::UnitsReset;
      size_q        <= '0;
      rd_q          <= '0;
      pend_q        <= 1'b0;
      pidx_q        <= '0;
      run_len_q     <= '0;
      run_start_q   <= '0;
      found_q       <= 1'b0;
      best_start_q  <= '0;
      best_margin_q <= '0;
      pos_q         <= '0;
      cnt_q         <= '0;
      wbit_q        <= 1'b0;
      res_status_q  <= bbfa_pkg::StatusOk;
      res_start_q   <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_status_q  <= bbfa_pkg::StatusOk;
      rsp_start_q   <= '0;
    end else begin
      state_q       <= state_d;
      mem_units_q   <= mem_units_d;
      size_q        <= size_d;
      rd_q          <= rd_d;
      pend_q        <= pend_d;
      pidx_q        <= pidx_d;
      run_len_q     <= run_len_d;
      run_start_q   <= run_start_d;
      found_q       <= found_d;
      best_start_q  <= best_start_d;
      best_margin_q <= best_margin_d;
      pos_q         <= pos_d;
      cnt_q         <= cnt_d;
      wbit_q        <= wbit_d;
      res_status_q  <= res_status_d;
      res_start_q   <= res_start_d;
      rsp_valid_q   <= rsp_valid_d;
      rsp_status_q  <= rsp_status_d;
      rsp_start_q   <= rsp_start_d;
    end
  end

endmodule

// ----- design/bbfa_checker.sv -----
module bbfa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        rsp_status_i,
  input logic [bbfa_pkg::StartW-1:0] rsp_block_start_i
);

  logic [1:0] outstanding_q;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // Requests accepted whose response has not been taken yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (req_fire && !rsp_fire) begin
      outstanding_q <= outstanding_q + 2'd1;
    end else if (!req_fire && rsp_fire) begin
      outstanding_q <= outstanding_q - 2'd1;
    end
  end

  // Nothing is accepted or offered while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> !req_ready_i && !rsp_valid_i)
    else $error("bbfa: handshake active during reset");

  // A response is only offered for a request that was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> outstanding_q != 2'd0)
    else $error("bbfa: response without a pending request");

  // At most one request is in work besides the one waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q == 2'd2 |-> !req_ready_i)
    else $error("bbfa: too many requests accepted");

  // A failed allocation reports start zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == bbfa_pkg::StatusNoFit |-> rsp_block_start_i == '0)
    else $error("bbfa: failed allocation with nonzero start");

  // A stalled response holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_block_start_i))
    else $error("bbfa: stalled response changed");

endmodule

bind bitmap_best_fit_allocator_core bbfa_checker u_bbfa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_block_start_i (rsp_o.block_start)
);

// ----- dv/testbench.sv -----
module testbench;

  localparam int unsigned MapUnits    = 1024;
  localparam int unsigned LimitCycles = 8_000_000;
  localparam int unsigned DrainCycles = 2 * MapUnits + 16;

  typedef struct packed {
    logic                        action;
    logic [bbfa_pkg::SizeW-1:0]  block_size;
    logic [bbfa_pkg::StartW-1:0] free_start;
  } alloc_req_t;

  typedef struct packed {
    logic                        status;
    logic [bbfa_pkg::StartW-1:0] block_start;
  } alloc_grant_t;

  typedef struct packed {
    logic [bbfa_pkg::StartW-1:0] start;
    logic [bbfa_pkg::SizeW-1:0]  len;
  } live_block_t;

  logic clk_i;
  logic rst_ni;

  bbfa_req_if req_if ();
  bbfa_rsp_if rsp_if ();
  bbfa_cfg_if cfg_if ();

  bitmap_best_fit_allocator_core #(
    .MEM_UNITS_MAX(MapUnits)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the allocator state.
  logic [MapUnits-1:0]           occ_map;
  logic [bbfa_pkg::UnitsW-1:0]   units_cfg;

  alloc_req_t   request_q[$];
  alloc_grant_t grant_q[$];
  live_block_t  live_blocks[$];

  alloc_req_t  req_cur;
  bit          req_taken;
  bit          idling_on;
  int unsigned req_gap;
  int unsigned rsp_stall;
  int unsigned n_pushed;
  int unsigned n_accepted;
  int unsigned n_placed;
  int unsigned n_nofit;
  int unsigned n_released;
  int unsigned n_sizes;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  // Best-fit placement and release on the shadow map.
  function automatic alloc_grant_t predict_grant(input alloc_req_t r);
    alloc_grant_t g;
    live_block_t  blk;
    int unsigned  units;
    int unsigned  sz;
    int unsigned  i;
    int unsigned  run_start;
    int unsigned  run_len;
    int unsigned  best_start;
    int unsigned  best_margin;
    bit           found;
    units       = (units_cfg > MapUnits) ? MapUnits : units_cfg;
    sz          = r.block_size;
    g.status    = bbfa_pkg::StatusOk;
    g.block_start = '0;
    if (r.action == bbfa_pkg::ActFree) begin
      // Release clipped at the in-use size.
      for (i = 0; i < sz && r.free_start + i < units; i++) begin
        occ_map[r.free_start + i] = 1'b0;
      end
      n_released++;
      return g;
    end
    found       = 1'b0;
    run_start   = 0;
    run_len     = 0;
    best_start  = 0;
    best_margin = 0;
    // Walk every free run; the end of the in-use area closes the last one.
    for (i = 0; i <= units; i++) begin
      if (i < units && !occ_map[i]) begin
        if (run_len == 0) begin
          run_start = i;
        end
        run_len++;
      end else begin
        if (run_len > 0 && run_len >= sz) begin
          if (!found || run_len - sz < best_margin) begin
            found       = 1'b1;
            best_margin = run_len - sz;
            best_start  = run_start;
          end
        end
        run_len = 0;
      end
    end
    if (!found) begin
      g.status = bbfa_pkg::StatusNoFit;
      n_nofit++;
      return g;
    end
    for (i = 0; i < sz; i++) begin
      if (best_start + i < MapUnits) begin
        occ_map[best_start + i] = 1'b1;
      end
    end
    g.block_start = best_start[bbfa_pkg::StartW-1:0];
    if (sz > 0) begin
      blk.start = best_start[bbfa_pkg::StartW-1:0];
      blk.len   = sz[bbfa_pkg::SizeW-1:0];
      live_blocks.insert(live_blocks.size(), blk);
    end
    n_placed++;
    return g;
  endfunction

  // Request driver: presents queued requests, holds each until taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      req_taken = 1'b0;
      if (req_gap > 0) begin
        req_if.valid <= 1'b0;
        req_gap--;
      end else if (request_q.size() > 0) begin
        req_cur = request_q.pop_front();
        req_if.valid      <= 1'b1;
        req_if.action     <= req_cur.action;
        req_if.block_size <= req_cur.block_size;
        req_if.free_start <= req_cur.free_start;
        req_gap = idling_on ? pick_gap() : 0;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Each accepted request transaction updates the shadow state.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      grant_q.insert(grant_q.size(), predict_grant(req_cur));
      req_taken = 1'b1;
      n_accepted++;
    end
  end

  // Response back-pressure.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_stall--;
    end else begin
      rsp_if.ready <= 1'b1;
      rsp_stall = idling_on ? pick_gap() : 0;
    end
  end

  // Response monitor: compare each transaction with the oldest expectation.
  always @(posedge clk_i) begin
    alloc_grant_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected response, status %0d block_start %0d",
                 $time, rsp_if.status, rsp_if.block_start);
        err_cnt++;
      end else begin
        want = grant_q.pop_front();
        if (rsp_if.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, rsp_if.status);
          err_cnt++;
        end
        if (rsp_if.block_start !== want.block_start) begin
          $display("%0t: block_start mismatch, expected %0d, actual %0d",
                   $time, want.block_start, rsp_if.block_start);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LimitCycles) begin
      $display("%0t: timeout, %0d of %0d requests accepted, %0d responses pending",
               $time, n_accepted, n_pushed, grant_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_req(input logic act, input int unsigned sz, input int unsigned start);
    alloc_req_t r;
    r.action     = act;
    r.block_size = sz[bbfa_pkg::SizeW-1:0];
    r.free_start = start[bbfa_pkg::StartW-1:0];
    request_q.insert(request_q.size(), r);
    n_pushed++;
  endtask

  // Wait until every request is taken and every response has come back.
  task automatic wait_idle();
    while (n_accepted != n_pushed || grant_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_mem_units(input int unsigned v);
    wait_idle();
    @(negedge clk_i);
    cfg_if.valid     = 1'b1;
    cfg_if.mem_units = v[bbfa_pkg::UnitsW-1:0];
    @(posedge clk_i);
    while (!cfg_if.ready) begin
      @(posedge clk_i);
    end
    units_cfg = v[bbfa_pkg::UnitsW-1:0];
    n_sizes++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // One random request: mostly allocations and releases of live blocks,
  // the rest stray releases anywhere.
  task automatic send_random(input int unsigned units);
    live_block_t blk;
    int unsigned roll;
    int unsigned k;
    int unsigned sz;
    int unsigned start;
    roll  = $urandom_range(0, 99);
    start = $urandom_range(0, MapUnits - 1);
    if (roll < 50) begin
      k = $urandom_range(0, 19);
      if (k == 0) begin
        sz = 0;
      end else if (k == 1) begin
        sz = $urandom_range(units, 2047);
      end else begin
        sz = $urandom_range(1, units / 4 + 1);
      end
      send_req(bbfa_pkg::ActAlloc, sz, start);
    end else if (roll < 88 && live_blocks.size() > 0) begin
      k   = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[k];
      live_blocks.delete(k);
      sz  = blk.len;
      if ($urandom_range(0, 7) == 0) begin
        sz = $urandom_range(0, blk.len);
      end
      send_req(bbfa_pkg::ActFree, sz, blk.start);
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        start = $urandom_range(0, units + 8);
      end
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 16);
      send_req(bbfa_pkg::ActFree, sz, start);
    end
  endtask

  // Stimulus: reset, directed cases, then random phases at several sizes.
  initial begin
    int unsigned cfg_val;
    int unsigned units;
    int unsigned n_items;
    int unsigned p;
    int unsigned j;
    occ_map           = '0;
    units_cfg         = bbfa_pkg::UnitsReset;
    req_taken         = 1'b0;
    idling_on         = 1'b0;
    req_gap           = 0;
    rsp_stall         = 0;
    n_pushed          = 0;
    n_accepted        = 0;
    n_placed          = 0;
    n_nofit           = 0;
    n_released        = 0;
    n_sizes           = 0;
    err_cnt           = 0;
    cycle_cnt         = 0;
    req_if.valid      = 1'b0;
    req_if.action     = bbfa_pkg::ActAlloc;
    req_if.block_size = '0;
    req_if.free_start = '0;
    rsp_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.mem_units  = bbfa_pkg::UnitsReset;
    rst_ni            = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset size: zero request, full map, overflow,
    // clipped releases, best fit over a larger hole, exact fit and ties.
    send_req(bbfa_pkg::ActAlloc, 0, 0);
    send_req(bbfa_pkg::ActAlloc, 1024, 1023);
    send_req(bbfa_pkg::ActAlloc, 1, 0);
    send_req(bbfa_pkg::ActFree, 2047, 0);
    send_req(bbfa_pkg::ActAlloc, 2047, 0);
    send_req(bbfa_pkg::ActAlloc, 10, 0);
    send_req(bbfa_pkg::ActAlloc, 20, 0);
    send_req(bbfa_pkg::ActAlloc, 5, 0);
    send_req(bbfa_pkg::ActFree, 20, 10);
    send_req(bbfa_pkg::ActAlloc, 15, 1023);
    send_req(bbfa_pkg::ActAlloc, 5, 0);
    send_req(bbfa_pkg::ActFree, 1, 1023);
    send_req(bbfa_pkg::ActFree, 0, 30);
    send_req(bbfa_pkg::ActFree, 3, 0);
    send_req(bbfa_pkg::ActFree, 3, 6);
    send_req(bbfa_pkg::ActAlloc, 2, 0);
    send_req(bbfa_pkg::ActAlloc, 0, 0);

    // No units in use: nothing fits and releases do nothing.
    write_mem_units(0);
    send_req(bbfa_pkg::ActAlloc, 1, 0);
    send_req(bbfa_pkg::ActAlloc, 0, 0);
    send_req(bbfa_pkg::ActFree, 5, 0);

    // Single unit in use, then a size beyond the map.
    write_mem_units(1);
    send_req(bbfa_pkg::ActFree, 4, 0);
    send_req(bbfa_pkg::ActAlloc, 1, 0);
    send_req(bbfa_pkg::ActAlloc, 1, 0);
    write_mem_units(2047);
    send_req(bbfa_pkg::ActAlloc, 1000, 0);
    send_req(bbfa_pkg::ActFree, 2047, 0);

    // Random phases; the large sizes get their share, most stay small.
    for (p = 0; p < 12; p++) begin
      unique case (p)
        3:       cfg_val = 1024;
        5:       cfg_val = 1;
        7:       cfg_val = 2047;
        9:       cfg_val = 0;
        default: cfg_val = $urandom_range(4, 96);
      endcase
      write_mem_units(cfg_val);
      units     = (cfg_val > MapUnits) ? MapUnits : cfg_val;
      n_items   = (units <= 1) ? 12 : 52;
      idling_on = ($urandom_range(0, 3) != 0);
      for (j = 0; j < n_items; j++) begin
        while (request_q.size() > 1) begin
          @(posedge clk_i);
        end
        // Now and then hold back until the block has answered everything.
        if ($urandom_range(0, 39) == 0) begin
          wait_idle();
        end
        if ($urandom_range(0, 24) == 0) begin
          idling_on = ~idling_on;
        end
        send_random(units);
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d requests over %0d in-use sizes from 0 to beyond the map.",
             n_accepted, n_sizes);
    $display("Allocations placed %0d, without fit %0d; releases %0d.",
             n_placed, n_nofit, n_released);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
